>>> hw/rtl/utfb_pkg.sv
// utfb_pkg: shared types and constants for the UTF-8 text frame builder.
// Used by utfb_framer, utfb_burst and utf8_text_frame_builder; no dependencies.
package utfb_pkg;

  // Item kinds on the input channel
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TEXT  = 1'b1;

  // Frame header constants
  localparam logic [7:0] HDR_SYNC = 8'hFD;
  localparam logic [7:0] HDR_ZERO = 8'h00;
  localparam logic [7:0] LEN_BIAS = 8'h03;

  // Division by three of a 9-bit length: (len * 683) >> 11 is exact below 512
  localparam logic [9:0] DIV3_MUL   = 10'd683;
  localparam int         DIV3_SHIFT = 11;

  // Register indexes on the configuration port (byte address 4*index)
  localparam logic [1:0] REG_COMMAND  = 2'd0;
  localparam logic [1:0] REG_ENCODING = 2'd1;
  localparam logic [1:0] REG_MUSIC    = 2'd2;

  // Register reset values
  localparam logic [7:0] CMD_RESET   = 8'h01;
  localparam logic [2:0] ENC_RESET   = 3'd3;
  localparam logic [4:0] MUSIC_RESET = 5'd0;

  // Group phases of the UTF-8 folding
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  // Most result bytes one item can cause
  localparam logic [2:0] BURST_MAX = 3'd6;

  // Bytes produced by one item, slot 0 leaves first
  typedef struct packed {
    logic [5:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            fend;   // last byte of the burst is the check byte
  } burst_t;

endpackage

>>> hw/rtl/utfb_framer.sv
// utfb_framer: frame state (length countdown, UTF-8 group holds, running XOR)
// and the byte burst each item produces. Depends on utfb_pkg.
module utfb_framer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_take,    // item leaves the input register
  input  logic                item_kind,
  input  logic [8:0]          item_length,
  input  logic [7:0]          item_quot,    // item_length / 3
  input  logic [7:0]          item_byte,
  input  logic [7:0]          command_code,
  input  logic [2:0]          text_encoding,
  input  logic [4:0]          music_select,
  output utfb_pkg::burst_t    burst
);

  logic       active_r, active_nxt;
  logic [8:0] remain_r, remain_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] hold1_r, hold1_nxt;
  logic [7:0] hold2_r, hold2_nxt;
  logic [7:0] xor_r, xor_nxt;

  logic [7:0] len_byte;
  logic [7:0] param_byte;
  logic [7:0] hi_byte;
  logic [7:0] lo_byte;
  logic [7:0] acc;

  assign len_byte   = {item_quot[6:0], 1'b0} + utfb_pkg::LEN_BIAS;
  assign param_byte = {music_select, text_encoding};
  assign hi_byte    = {hold1_r[3:0], hold2_r[5:2]};
  assign lo_byte    = {hold2_r[1:0], item_byte[5:0]};

  // Burst and next state for the item in the input register
  always_comb begin
    active_nxt = active_r;
    remain_nxt = remain_r;
    phase_nxt  = phase_r;
    hold1_nxt  = hold1_r;
    hold2_nxt  = hold2_r;
    xor_nxt    = xor_r;
    acc        = xor_r;
    burst      = '0;
    if (item_kind == utfb_pkg::KIND_START) begin
      burst.bytes[0] = utfb_pkg::HDR_SYNC;
      burst.bytes[1] = utfb_pkg::HDR_ZERO;
      burst.bytes[2] = len_byte;
      burst.bytes[3] = command_code;
      burst.bytes[4] = param_byte;
      burst.cnt      = 3'd5;
      acc = utfb_pkg::HDR_SYNC ^ utfb_pkg::HDR_ZERO ^ len_byte ^ command_code ^ param_byte;
      remain_nxt = item_length;
      phase_nxt  = utfb_pkg::PH_FIRST;
      hold1_nxt  = '0;
      hold2_nxt  = '0;
      active_nxt = 1'b1;
      xor_nxt    = acc;
      // empty text closes the frame at once
      if (item_length == '0) begin
        burst.bytes[5] = acc;
        burst.cnt      = utfb_pkg::BURST_MAX;
        burst.fend     = 1'b1;
        active_nxt     = 1'b0;
        xor_nxt        = '0;
      end
    end else if (active_r) begin
      remain_nxt = remain_r - 9'd1;
      case (phase_r)
        utfb_pkg::PH_FIRST: begin
          hold1_nxt = item_byte;
          phase_nxt = utfb_pkg::PH_SECOND;
        end
        utfb_pkg::PH_SECOND: begin
          hold2_nxt = item_byte;
          phase_nxt = utfb_pkg::PH_THIRD;
        end
        default: begin
          // third byte completes the group (unreachable phase behaves alike)
          burst.bytes[0] = hi_byte;
          burst.bytes[1] = lo_byte;
          burst.cnt      = 3'd2;
          acc            = xor_r ^ hi_byte ^ lo_byte;
          phase_nxt      = utfb_pkg::PH_FIRST;
        end
      endcase
      xor_nxt = acc;
      // last declared byte: append the check byte
      if (remain_nxt == '0) begin
        if (burst.cnt == '0) begin
          burst.bytes[0] = acc;
        end else begin
          burst.bytes[2] = acc;
        end
        burst.cnt  = burst.cnt + 3'd1;
        burst.fend = 1'b1;
        active_nxt = 1'b0;
        phase_nxt  = utfb_pkg::PH_FIRST;
        xor_nxt    = '0;
      end
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      remain_r <= '0;
      phase_r  <= utfb_pkg::PH_FIRST;
      hold1_r  <= '0;
      hold2_r  <= '0;
      xor_r    <= '0;
    end else if (item_take) begin
      active_r <= active_nxt;
      remain_r <= remain_nxt;
      phase_r  <= phase_nxt;
      hold1_r  <= hold1_nxt;
      hold2_r  <= hold2_nxt;
      xor_r    <= xor_nxt;
    end
  end

endmodule

>>> hw/rtl/utfb_burst.sv
// utfb_burst: result register holding one item's burst, sent one byte per beat.
// Depends on utfb_pkg.
module utfb_burst (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  utfb_pkg::burst_t  burst,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [7:0]        out_frame_byte,
  output logic              out_run_last,
  output logic              out_frame_end,
  output logic              free          // can take a new burst this cycle
);

  logic [5:0][7:0] bytes_r;
  logic [2:0]      cnt_r;
  logic            fend_r;
  logic            take;

  assign take           = out_valid && !out_stall;
  assign out_valid      = (cnt_r != '0);
  assign out_frame_byte = bytes_r[0];
  assign out_run_last   = (cnt_r == 3'd1);
  assign out_frame_end  = out_run_last && fend_r;
  assign free           = (cnt_r == '0) || (out_run_last && !out_stall);

  // Count of bytes still to send
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= burst.cnt;
    end else if (take) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  // Byte slots shift towards slot 0 on each beat
  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= burst.bytes;
      fend_r  <= burst.fend;
    end else if (take) begin
      bytes_r <= {8'h00, bytes_r[5:1]};
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= utfb_pkg::BURST_MAX)
    else $error("burst count beyond six");

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("burst loaded over unsent bytes");

endmodule

>>> hw/rtl/utf8_text_frame_builder.sv
// utf8_text_frame_builder: top level; input register, configuration registers,
// framer and result burst. Depends on utfb_pkg, utfb_framer, utfb_burst.
//
// Each accepted item lands in an input register, where a start item's length is
// already divided by three; the framer turns it into a burst of up to six frame
// bytes (five header bytes and, for an empty text, a check byte for a start; up
// to two UCS-2 bytes and a check byte for text), loaded into the result register
// once that is free and sent one byte per beat, so the output port sets the rate;
// an item causing no bytes leaves the input register without waiting. A new item
// is accepted while the previous burst is still being sent, and the input register
// hands over as the last byte of a burst leaves. An item passes the input register
// and then the result register before its first byte appears. Config registers are
// at byte addresses 0 (command), 4 (encoding) and 8 (music); pready is always high.
module utf8_text_frame_builder (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [8:0]  in_text_length,
  input  logic [7:0]  in_text_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_byte,
  output logic        out_run_last,
  output logic        out_frame_end,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  cmd_r;
  logic [2:0]  enc_r;
  logic [4:0]  music_r;
  logic        cfg_write;
  logic [1:0]  cfg_index;

  logic        in_v_r;
  logic        kind_r;
  logic [8:0]  len_r;
  logic [7:0]  quot_r;
  logic [7:0]  tbyte_r;
  logic [18:0] div_prod;
  logic        in_take;
  logic        advance;

  utfb_pkg::burst_t burst;
  logic        burst_free;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= utfb_pkg::CMD_RESET;
      enc_r   <= utfb_pkg::ENC_RESET;
      music_r <= utfb_pkg::MUSIC_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        utfb_pkg::REG_COMMAND:  cmd_r   <= pwdata[7:0];
        utfb_pkg::REG_ENCODING: enc_r   <= pwdata[2:0];
        utfb_pkg::REG_MUSIC:    music_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      utfb_pkg::REG_COMMAND:  prdata = {24'h0, cmd_r};
      utfb_pkg::REG_ENCODING: prdata = {29'h0, enc_r};
      utfb_pkg::REG_MUSIC:    prdata = {27'h0, music_r};
      default:                prdata = '0;
    endcase
  end

  // Input register; a length is divided by three on the way in
  assign div_prod = {10'h000, in_text_length} * {9'h000, utfb_pkg::DIV3_MUL};
  assign advance  = in_v_r && (burst_free || (burst.cnt == '0));
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_r  <= in_kind;
      len_r   <= in_text_length;
      quot_r  <= div_prod[utfb_pkg::DIV3_SHIFT +: 8];
      tbyte_r <= in_text_byte;
    end
  end

  utfb_framer u_framer (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_take     (advance),
    .item_kind     (kind_r),
    .item_length   (len_r),
    .item_quot     (quot_r),
    .item_byte     (tbyte_r),
    .command_code  (cmd_r),
    .text_encoding (enc_r),
    .music_select  (music_r),
    .burst         (burst)
  );

  utfb_burst u_burst (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (advance && (burst.cnt != '0)),
    .burst          (burst),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_frame_byte (out_frame_byte),
    .out_run_last   (out_run_last),
    .out_frame_end  (out_frame_end),
    .free           (burst_free)
  );

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_frame_end |-> out_run_last)
    else $error("check byte not at end of burst");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_v_r)
    else $error("input stalled with empty input register");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_v_r)
    else $error("beat pending after reset");

endmodule
